/* rtl/core/clns_pkg.sv */
// Shared constants, codes and controller/datapath types of the nibble sequencer.
package clns_pkg;

  // Request kinds.
  localparam logic [2:0] KIND_INIT   = 3'd0;
  localparam logic [2:0] KIND_ON     = 3'd1;
  localparam logic [2:0] KIND_OFF    = 3'd2;
  localparam logic [2:0] KIND_CLEAR  = 3'd3;
  localparam logic [2:0] KIND_HOME   = 3'd4;
  localparam logic [2:0] KIND_CURSOR = 3'd5;
  localparam logic [2:0] KIND_SHIFT  = 3'd6;
  localparam logic [2:0] KIND_CHAR   = 3'd7;

  // Controller command bytes.
  localparam logic [7:0] CMD_FUNC_SET    = 8'h28;
  localparam logic [7:0] CMD_DISP_OFF    = 8'h08;
  localparam logic [7:0] CMD_CLEAR       = 8'h01;
  localparam logic [7:0] CMD_DISP_ON     = 8'h0E;
  localparam logic [7:0] CMD_ENTRY_MODE  = 8'h06;
  localparam logic [7:0] CMD_HOME        = 8'h02;
  localparam logic [7:0] CMD_SET_DDRAM   = 8'h80;
  localparam logic [7:0] CMD_SHIFT_LEFT  = 8'h18;
  localparam logic [7:0] CMD_SHIFT_RIGHT = 8'h1C;

  // Wake-up nibbles and their fixed waits.
  localparam logic [3:0]  WAKE_NIBBLE   = 4'h3;
  localparam logic [3:0]  FOUR_BIT_NIB  = 4'h2;
  localparam logic [15:0] WAKE_WAIT2_US = 16'd5000;
  localparam logic [15:0] WAKE_WAIT3_US = 16'd100;
  localparam int          INIT_XFERS    = 14;

  // Configuration register indexes and reset values.
  localparam logic [1:0]  REG_NORMAL_WAIT = 2'd0;
  localparam logic [1:0]  REG_LONG_WAIT   = 2'd1;
  localparam logic [1:0]  REG_POWER_WAIT  = 2'd2;
  localparam logic [9:0]  NORMAL_WAIT_RST = 10'd40;
  localparam logic [11:0] LONG_WAIT_RST   = 12'd1640;
  localparam logic [15:0] POWER_WAIT_RST  = 16'd15000;

  typedef struct packed {
    logic load;   // latch a new request
    logic step;   // current transfer beat taken
  } ctrl_cmd_t;

  typedef struct packed {
    logic empty;  // latched request gives no transfers
    logic last;   // current transfer closes the request
  } dp_sts_t;

  // Byte sent after the wake-up nibbles, by position.
  function automatic logic [7:0] init_byte(input logic [2:0] pos);
    logic [7:0] b;
    case (pos)
      3'd0:    b = CMD_FUNC_SET;
      3'd1:    b = CMD_DISP_OFF;
      3'd2:    b = CMD_CLEAR;
      3'd3:    b = CMD_DISP_ON;
      3'd4:    b = CMD_ENTRY_MODE;
      default: b = CMD_ENTRY_MODE;
    endcase
    return b;
  endfunction

endpackage

/* rtl/core/clns_if.sv */
// Valid/ready channel interfaces for requests and nibble transfers.
interface clns_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        kind;
  logic [7:0]        char_code;
  logic [5:0]        column;
  logic [1:0]        row;
  logic signed [5:0] shift_amount;

  modport source (output valid, kind, char_code, column, row, shift_amount, input ready);
  modport sink   (input valid, kind, char_code, column, row, shift_amount, output ready);
endinterface

interface clns_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] wait_before_us;
  logic        reg_select;
  logic [3:0]  nibble;
  logic        last;

  modport source (output valid, wait_before_us, reg_select, nibble, last, input ready);
  modport sink   (input valid, wait_before_us, reg_select, nibble, last, output ready);
endinterface

/* rtl/core/clns_ctrl.sv */
// Controller state machine: takes a request, checks it and runs its transfers.
module clns_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  output clns_pkg::ctrl_cmd_t    cmd,
  input  clns_pkg::dp_sts_t      sts
);
  import clns_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;

  logic [1:0] state_r, state_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_RUN);
  assign cmd.load  = in_valid && in_ready;
  assign cmd.step  = out_valid && out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.load) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = sts.empty ? ST_IDLE : ST_RUN;
      end
      ST_RUN: begin
        if (cmd.step && sts.last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("request taken while transfers pending");

  a_load_checks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (!in_ready && !out_valid)) else $error("new request not checked first");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && sts.last) |=> in_ready) else $error("sequencer not idle after last beat");

endmodule

/* rtl/core/clns_dp.sv */
// Datapath: latched request, transfer index, owed wait and nibble generation.
module clns_dp #(
  parameter int MAX_SHIFT = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  clns_pkg::ctrl_cmd_t cmd,
  output clns_pkg::dp_sts_t   sts,
  input  logic [2:0]          in_kind,
  input  logic [7:0]          in_char_code,
  input  logic [5:0]          in_column,
  input  logic [1:0]          in_row,
  input  logic signed [5:0]   in_shift_amount,
  input  logic [9:0]          normal_wait,
  input  logic [11:0]         long_wait,
  input  logic [15:0]         power_wait,
  output logic [15:0]         out_wait_before_us,
  output logic                out_reg_select,
  output logic [3:0]          out_nibble,
  output logic                out_last
);
  import clns_pkg::*;

  localparam int MAX_XFER = (2 * MAX_SHIFT > INIT_XFERS) ? 2 * MAX_SHIFT : INIT_XFERS;
  localparam int CNT_W    = $clog2(MAX_XFER + 1);

  logic [2:0]       kind_r;
  logic [7:0]       byte_r, byte_nxt;
  logic [CNT_W-1:0] total_r, total_nxt;
  logic [CNT_W-1:0] idx_r;
  logic [15:0]      owed_r;

  logic             neg;
  logic [5:0]       mag;
  logic [CNT_W-1:0] init_off;
  logic             is_init, wake_phase, high_half;
  logic [7:0]       cur_byte;
  logic [16:0]      first_sum;
  logic [15:0]      owed_after;

  // Request decode at load time.
  always_comb begin
    neg       = in_shift_amount[5];
    mag       = neg ? (6'd0 - in_shift_amount) : in_shift_amount;
    byte_nxt  = in_char_code;
    total_nxt = '0;
    unique case (in_kind)
      KIND_INIT: begin
        total_nxt = CNT_W'(INIT_XFERS);
      end
      KIND_ON: begin
        byte_nxt  = CMD_DISP_ON;
        total_nxt = CNT_W'(2);
      end
      KIND_OFF: begin
        byte_nxt  = CMD_DISP_OFF;
        total_nxt = CNT_W'(2);
      end
      KIND_CLEAR: begin
        byte_nxt  = CMD_CLEAR;
        total_nxt = CNT_W'(2);
      end
      KIND_HOME: begin
        byte_nxt  = CMD_HOME;
        total_nxt = CNT_W'(2);
      end
      KIND_CURSOR: begin
        byte_nxt = CMD_SET_DDRAM | {1'b0, in_row[0], in_column};
        if (!in_column[5] && !in_row[1]) total_nxt = CNT_W'(2);
      end
      KIND_SHIFT: begin
        byte_nxt = neg ? CMD_SHIFT_LEFT : CMD_SHIFT_RIGHT;
        if (mag <= 6'(MAX_SHIFT)) total_nxt = CNT_W'({mag, 1'b0});
      end
      KIND_CHAR: begin
        byte_nxt  = in_char_code;
        total_nxt = CNT_W'(2);
      end
      default: total_nxt = '0;
    endcase
  end

  // Transfer generation from the current index.
  always_comb begin
    is_init    = (kind_r == KIND_INIT);
    wake_phase = is_init && (idx_r < CNT_W'(4));
    high_half  = !idx_r[0];
    init_off   = idx_r - CNT_W'(4);
    cur_byte   = is_init ? init_byte(init_off[3:1]) : byte_r;
    first_sum  = {1'b0, owed_r} + {1'b0, power_wait};

    if (wake_phase) begin
      out_nibble = (idx_r[1:0] == 2'd3) ? FOUR_BIT_NIB : WAKE_NIBBLE;
      case (idx_r[1:0])
        2'd0:    out_wait_before_us = first_sum[16] ? 16'hFFFF : first_sum[15:0];
        2'd1:    out_wait_before_us = WAKE_WAIT2_US;
        2'd2:    out_wait_before_us = WAKE_WAIT3_US;
        default: out_wait_before_us = 16'(normal_wait);
      endcase
    end else begin
      out_nibble         = high_half ? cur_byte[7:4] : cur_byte[3:0];
      out_wait_before_us = high_half ? owed_r : 16'd0;
    end

    out_reg_select = (kind_r == KIND_CHAR);
    out_last       = ((idx_r + CNT_W'(1)) == total_r);

    // Clear and home commands owe the long wait; everything else the normal one.
    if (!out_reg_select && (cur_byte == CMD_CLEAR || cur_byte == CMD_HOME)) begin
      owed_after = 16'(long_wait);
    end else begin
      owed_after = 16'(normal_wait);
    end
  end

  assign sts.empty = (total_r == '0);
  assign sts.last  = out_last;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= in_kind;
      byte_r  <= byte_nxt;
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      owed_r <= '0;
    end else begin
      if (cmd.load) begin
        idx_r <= '0;
      end else if (cmd.step) begin
        idx_r <= idx_r + CNT_W'(1);
        if (wake_phase) begin
          if (idx_r[1:0] == 2'd3) owed_r <= 16'(normal_wait);
        end else if (!high_half) begin
          owed_r <= owed_after;
        end
      end
    end
  end

endmodule

/* rtl/core/char_lcd_nibble_sequencer.sv */
// Top level: configuration registers, controller and datapath of the nibble sequencer.
//
//  channel | direction | handshake            | carries
//  in_ch   | sink      | valid/ready          | kind, char_code, column, row, shift_amount
//  out_ch  | source    | valid/ready          | wait_before_us, reg_select, nibble, last
//  cfg_*   | slave     | APB, pready always 1 | normal, long and power-up waits
//
// A request is taken only while the sequencer is idle; it is decoded as it is taken,
// checked in the cycle after that, and then one nibble beat is offered per cycle while
// the output takes them (init 14 transfers, an ordinary byte 2, a shift of n steps 2n).
// A request that gives no transfers goes from the check state straight back to idle.
// A stalled output holds its beat; the transfer index only advances on a taken beat.
// Synchronous reset restores the register defaults and clears the owed wait.
module char_lcd_nibble_sequencer #(
  parameter int MAX_SHIFT = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  clns_in_if.sink     in_ch,
  clns_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import clns_pkg::*;

  logic [9:0]  normal_wait_r;
  logic [11:0] long_wait_r;
  logic [15:0] power_wait_r;
  logic        cfg_wr;
  ctrl_cmd_t   cmd;
  dp_sts_t     sts;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      normal_wait_r <= NORMAL_WAIT_RST;
      long_wait_r   <= LONG_WAIT_RST;
      power_wait_r  <= POWER_WAIT_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_NORMAL_WAIT: normal_wait_r <= cfg_pwdata[9:0];
        REG_LONG_WAIT:   long_wait_r   <= cfg_pwdata[11:0];
        REG_POWER_WAIT:  power_wait_r  <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_NORMAL_WAIT: cfg_prdata = 32'(normal_wait_r);
      REG_LONG_WAIT:   cfg_prdata = 32'(long_wait_r);
      REG_POWER_WAIT:  cfg_prdata = 32'(power_wait_r);
      default:         cfg_prdata = 32'd0;
    endcase
  end

  clns_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  clns_dp #(
    .MAX_SHIFT (MAX_SHIFT)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_kind            (in_ch.kind),
    .in_char_code       (in_ch.char_code),
    .in_column          (in_ch.column),
    .in_row             (in_ch.row),
    .in_shift_amount    (in_ch.shift_amount),
    .normal_wait        (normal_wait_r),
    .long_wait          (long_wait_r),
    .power_wait         (power_wait_r),
    .out_wait_before_us (out_ch.wait_before_us),
    .out_reg_select     (out_ch.reg_select),
    .out_nibble         (out_ch.nibble),
    .out_last           (out_ch.last)
  );

endmodule
